// File: src/wbhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbhe_pkg
// Shared constants, types and the arctangent table of the bearing pipeline.
// ----------------------------------------------------------------------------
package wbhe_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int ANG_W   = 16;
  localparam int N_W     = LAT_W + 1;
  localparam int E_W     = LON_W + 1;
  localparam int VEC_SHIFT = 24;
  localparam int XW      = 60;
  localparam int ACC_W   = 32;
  localparam int FRAC_BITS = 16;

  localparam int DEG180 = 18000;
  localparam int DEG360 = 36000;
  localparam int DEG720 = 72000;

  localparam int PREP_STAGES = 2;
  localparam int POST_STAGES = 4;
  localparam int NSTAGE      = PREP_STAGES + NSTEP + POST_STAGES;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LAT = 2'd0,
    REG_TARGET_LON = 2'd1
  } wbhe_reg_e;

  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
    logic [HEAD_W-1:0]       head;
  } wbhe_vec_t;

  // atan(2^-i) in 1/65536 of 0.01 degree
  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
    logic signed [ACC_W-1:0] v;
    begin
      case (idx)
        0:  v = 32'sd294912000;
        1:  v = 32'sd174096719;
        2:  v = 32'sd91987925;
        3:  v = 32'sd46694507;
        4:  v = 32'sd23437865;
        5:  v = 32'sd11730358;
        6:  v = 32'sd5866610;
        7:  v = 32'sd2933484;
        8:  v = 32'sd1466764;
        9:  v = 32'sd733385;
        10: v = 32'sd366693;
        11: v = 32'sd183346;
        12: v = 32'sd91673;
        13: v = 32'sd45837;
        14: v = 32'sd22918;
        15: v = 32'sd11459;
        16: v = 32'sd5730;
        17: v = 32'sd2865;
        18: v = 32'sd1432;
        19: v = 32'sd716;
        20: v = 32'sd358;
        21: v = 32'sd179;
        22: v = 32'sd90;
        23: v = 32'sd45;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: src/waypoint_bearing_heading_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_bearing_heading_error
// Flat-plane bearing to a target point and signed heading error.
// ----------------------------------------------------------------------------
// Usage:
//   Target latitude and longitude are written on the cfg channel (index 0 and
//   1, always ready) while no request is in flight. Each request on the in
//   channel (boat position and heading) yields exactly one result on the out
//   channel: bearing in [0,36000) and heading error in [-18000,18000), both in
//   0.01 degree.
//   The pipeline has two preparation stages, one stage per CORDIC micro-rotation
//   (16 CORDIC steps) and four output stages.
//   Throughput is one request per cycle while the out channel accepts results;
//   the depth of the unrolled CORDIC sets the latency, not the rate.
//   Each stage holds a valid bit and advances when it is empty or the stage
//   after it advances, so bubbles close up during an out stall; in_ready_o
//   drops only once every stage holds a request.
//   Reset clears the valid bits and both target registers to zero.
// ----------------------------------------------------------------------------
module waypoint_bearing_heading_error (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wbhe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wbhe_pkg::CFG_DW-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [wbhe_pkg::LAT_W-1:0]     boat_lat_i,
  input  logic signed [wbhe_pkg::LON_W-1:0]     boat_lon_i,
  input  logic [wbhe_pkg::HEAD_W-1:0]           boat_heading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wbhe_pkg::ANG_W-1:0]            target_bearing_o,
  output logic signed [wbhe_pkg::ANG_W-1:0]     heading_error_o
);
  import wbhe_pkg::*;

  logic signed [LAT_W-1:0] target_lat_q;
  logic signed [LON_W-1:0] target_lon_q;
  logic [NSTAGE-1:0]       vld_q;
  logic [NSTAGE-1:0]       en;
  wbhe_vec_t               prep_vec, cordic_vec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_lat_q <= '0;
      target_lon_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TARGET_LAT: target_lat_q <= cfg_data_i[LAT_W-1:0];
        REG_TARGET_LON: target_lon_q <= cfg_data_i[LON_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  wbhe_prep u_prep (
    .clk_i          (clk_i),
    .en_i           (en[PREP_STAGES-1:0]),
    .target_lat_i   (target_lat_q),
    .target_lon_i   (target_lon_q),
    .boat_lat_i     (boat_lat_i),
    .boat_lon_i     (boat_lon_i),
    .boat_heading_i (boat_heading_i),
    .vec_o          (prep_vec)
  );

  wbhe_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en[PREP_STAGES+NSTEP-1:PREP_STAGES]),
    .vec_i (prep_vec),
    .vec_o (cordic_vec)
  );

  wbhe_post u_post (
    .clk_i            (clk_i),
    .en_i             (en[NSTAGE-1:PREP_STAGES+NSTEP]),
    .vec_i            (cordic_vec),
    .target_bearing_o (target_bearing_o),
    .heading_error_o  (heading_error_o)
  );

  a_bearing_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (target_bearing_o < ANG_W'(DEG360)))
    else $error("bearing out of range");

  a_error_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((heading_error_o >= -ANG_W'(DEG180)) &&
                     (heading_error_o < ANG_W'(DEG180))))
    else $error("heading error out of range");

  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("input blocked with a free stage");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("pending result dropped");

endmodule

// File: src/wbhe_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbhe_prep
// Position differences, then scaling and half-plane pre-rotation.
// ----------------------------------------------------------------------------
module wbhe_prep (
  input  logic                                  clk_i,
  input  logic [wbhe_pkg::PREP_STAGES-1:0]      en_i,
  input  logic signed [wbhe_pkg::LAT_W-1:0]     target_lat_i,
  input  logic signed [wbhe_pkg::LON_W-1:0]     target_lon_i,
  input  logic signed [wbhe_pkg::LAT_W-1:0]     boat_lat_i,
  input  logic signed [wbhe_pkg::LON_W-1:0]     boat_lon_i,
  input  logic [wbhe_pkg::HEAD_W-1:0]           boat_heading_i,
  output wbhe_pkg::wbhe_vec_t                   vec_o
);
  import wbhe_pkg::*;

  logic signed [N_W-1:0]   n_q, n_d;
  logic signed [E_W-1:0]   e_q, e_d;
  logic [HEAD_W-1:0]       head_q;
  logic signed [N_W:0]     nsel;
  logic signed [E_W:0]     esel;
  logic                    neg;
  wbhe_vec_t               vec_q, vec_d;

  assign n_d = N_W'(target_lat_i) - N_W'(boat_lat_i);
  assign e_d = E_W'(target_lon_i) - E_W'(boat_lon_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n_q    <= n_d;
      e_q    <= e_d;
      head_q <= boat_heading_i;
    end
  end

  always_comb begin
    neg  = n_q[N_W-1];
    nsel = neg ? -(N_W+1)'(n_q) : (N_W+1)'(n_q);
    esel = neg ? -(E_W+1)'(e_q) : (E_W+1)'(e_q);
    vec_d.x    = {{(XW-VEC_SHIFT-N_W-1){nsel[N_W]}}, nsel, {VEC_SHIFT{1'b0}}};
    vec_d.y    = {{(XW-VEC_SHIFT-E_W-1){esel[E_W]}}, esel, {VEC_SHIFT{1'b0}}};
    vec_d.acc  = neg ? ACC_W'(DEG180 << FRAC_BITS) : '0;
    vec_d.zero = (n_q == '0) && (e_q == '0);
    vec_d.head = head_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// File: src/wbhe_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbhe_cordic
// Vectoring CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module wbhe_cordic (
  input  logic                        clk_i,
  input  logic [wbhe_pkg::NSTEP-1:0]  en_i,
  input  wbhe_pkg::wbhe_vec_t         vec_i,
  output wbhe_pkg::wbhe_vec_t         vec_o
);
  import wbhe_pkg::*;

  wbhe_vec_t stg_q [NSTEP];

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    wbhe_vec_t src, nxt;
    logic signed [XW-1:0] dx, dy;

    if (g == 0) begin : g_first
      assign src = vec_i;
    end else begin : g_rest
      assign src = stg_q[g-1];
    end

    always_comb begin
      dx  = src.y >>> g;
      dy  = src.x >>> g;
      nxt = src;
      if (!src.y[XW-1]) begin
        nxt.x   = src.x + dx;
        nxt.y   = src.y - dy;
        nxt.acc = src.acc + atan_entry(g);
      end else begin
        nxt.x   = src.x - dx;
        nxt.y   = src.y + dy;
        nxt.acc = src.acc - atan_entry(g);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        stg_q[g] <= nxt;
      end
    end
  end

  assign vec_o = stg_q[NSTEP-1];

endmodule

// File: src/wbhe_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbhe_post
// Angle wrap and rounding to 0.01 degree, then heading error wrap.
// ----------------------------------------------------------------------------
module wbhe_post (
  input  logic                               clk_i,
  input  logic [wbhe_pkg::POST_STAGES-1:0]   en_i,
  input  wbhe_pkg::wbhe_vec_t                vec_i,
  output logic [wbhe_pkg::ANG_W-1:0]         target_bearing_o,
  output logic signed [wbhe_pkg::ANG_W-1:0]  heading_error_o
);
  import wbhe_pkg::*;

  localparam logic [ACC_W:0] FULL = (ACC_W+1)'(64'(DEG360) << FRAC_BITS);
  localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1 << (FRAC_BITS - 1));
  localparam int             TW   = 18;

  // stage 1
  logic [ACC_W-1:0]    accw_q, accw_d;
  logic [ACC_W:0]      wsum;
  logic                zero1_q;
  logic [HEAD_W-1:0]   head1_q;
  // stage 2
  logic [ACC_W:0]      rsum;
  logic [ACC_W-FRAC_BITS:0] h;
  logic [ANG_W-1:0]    brg2_q, brg2_d;
  logic [HEAD_W-1:0]   head2_q;
  // stage 3
  logic [TW-1:0]       t;
  logic [ANG_W-1:0]    red3_q, red3_d;
  logic [ANG_W-1:0]    brg3_q;
  // stage 4
  logic signed [ANG_W:0] err_full;
  logic [ANG_W-1:0]    brg4_q;
  logic signed [ANG_W-1:0] err4_q, err4_d;

  always_comb begin
    wsum   = {vec_i.acc[ACC_W-1], vec_i.acc} + FULL;
    accw_d = vec_i.acc[ACC_W-1] ? wsum[ACC_W-1:0] : vec_i.acc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      accw_q  <= accw_d;
      zero1_q <= vec_i.zero;
      head1_q <= vec_i.head;
    end
  end

  always_comb begin
    rsum = {1'b0, accw_q} + HALF;
    h    = rsum[ACC_W:FRAC_BITS];
    if (zero1_q || (h >= (ACC_W-FRAC_BITS+1)'(DEG360))) begin
      brg2_d = '0;
    end else begin
      brg2_d = h[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      brg2_q  <= brg2_d;
      head2_q <= head1_q;
    end
  end

  always_comb begin
    t = TW'(brg2_q) + TW'(DEG720) - TW'(head2_q);
    if (t >= TW'(DEG720)) begin
      red3_d = ANG_W'(t - TW'(DEG720));
    end else if (t >= TW'(DEG360)) begin
      red3_d = ANG_W'(t - TW'(DEG360));
    end else begin
      red3_d = t[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      red3_q <= red3_d;
      brg3_q <= brg2_q;
    end
  end

  always_comb begin
    err_full = $signed({1'b0, red3_q}) - (ANG_W+1)'(DEG360);
    err4_d   = (red3_q >= ANG_W'(DEG180)) ? err_full[ANG_W-1:0] : $signed(red3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      err4_q <= err4_d;
      brg4_q <= brg3_q;
    end
  end

  assign target_bearing_o = brg4_q;
  assign heading_error_o  = err4_q;

endmodule

// File: tb/tb_waypoint_bearing_heading_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waypoint_bearing_heading_error
// Checks the bearing and heading error of every position fix against its
// typed table result or else an integer CORDIC predictor kept in step with
// the target registers. A short table of fixes comes first, then random fixes
// under several targets and back-pressure profiles, with one long output stall.
// ----------------------------------------------------------------------------
module tb_waypoint_bearing_heading_error;
  import wbhe_pkg::*;

  localparam int LATENCY     = NSTEP + 6;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS   = 263;

  localparam longint ATAN_STEP [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  typedef struct packed {
    logic                     typed;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
    logic [HEAD_W-1:0]        head;
    logic [ANG_W-1:0]         bearing;
    logic signed [ANG_W-1:0]  herr;
  } fix_row_t;

  typedef struct {
    logic [ANG_W-1:0]        bearing;
    logic signed [ANG_W-1:0] herr;
  } fix_result_t;

  // target (0,0) after reset; only coincident rows carry a typed result
  localparam int N_ROWS = 23;
  localparam fix_row_t FIX_TABLE [N_ROWS] = '{
    '{1'b1, 31'sd0, 32'sd0, 16'd0, 16'd0, 16'sd0},
    '{1'b1, 31'sd0, 32'sd0, 16'd18000, 16'd0, -16'sd18000},
    '{1'b1, 31'sd0, 32'sd0, 16'd35999, 16'd0, 16'sd1},
    '{1'b1, 31'sd0, 32'sd0, 16'd36000, 16'd0, 16'sd0},
    '{1'b1, 31'sd0, 32'sd0, 16'hffff, 16'd0, 16'sd6465},
    '{1'b0, -31'sd1000, 32'sd0, 16'd0, 16'd0, 16'sd0},
    '{1'b0, 31'sd1000, 32'sd0, 16'd9000, 16'd0, 16'sd0},
    '{1'b0, 31'sd0, -32'sd1000, 16'd27000, 16'd0, 16'sd0},
    '{1'b0, 31'sd0, 32'sd1000, 16'd9000, 16'd0, 16'sd0},
    '{1'b0, -31'sd500, -32'sd500, 16'd22500, 16'd0, 16'sd0},
    '{1'b0, 31'sd900000000, 32'sd1800000000, 16'd35999, 16'd0, 16'sd0},
    '{1'b0, -31'sd900000000, -32'sd1800000000, 16'd0, 16'd0, 16'sd0},
    '{1'b0, 31'h3fffffff, 32'h7fffffff, 16'hffff, 16'd0, 16'sd0},
    '{1'b0, 31'h40000000, 32'h80000000, 16'd0, 16'd0, 16'sd0},
    '{1'b0, 31'h3fffffff, 32'h80000000, 16'd18000, 16'd0, 16'sd0},
    '{1'b0, 31'h40000000, 32'h7fffffff, 16'd12345, 16'd0, 16'sd0},
    '{1'b0, 31'sd0, 32'h80000000, 16'd0, 16'd0, 16'sd0},
    '{1'b0, -31'sd1, 32'sd0, 16'd1, 16'd0, 16'sd0},
    '{1'b0, 31'sd1, -32'sd1, 16'd0, 16'd0, 16'sd0},
    '{1'b0, 31'sd900000000, 32'sd0, 16'd36000, 16'd0, 16'sd0},
    '{1'b0, 31'sd0, 32'sd1, 16'd27000, 16'd0, 16'sd0},
    '{1'b0, 31'h2aaaaaaa, 32'h55555555, 16'haaaa, 16'd0, 16'sd0},
    '{1'b0, 31'h55555555, 32'haaaaaaaa, 16'h5555, 16'd0, 16'sd0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  wbhe_reg_e               cfg_index = REG_TARGET_LAT;
  logic [CFG_DW-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [LAT_W-1:0] boat_lat = '0;
  logic signed [LON_W-1:0] boat_lon = '0;
  logic [HEAD_W-1:0]       boat_heading = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ANG_W-1:0]        target_bearing;
  logic signed [ANG_W-1:0] heading_error;

  logic                    row_typed = 1'b0;
  logic [ANG_W-1:0]        row_bearing = '0;
  logic signed [ANG_W-1:0] row_herr = '0;

  logic signed [LAT_W-1:0] cur_lat = '0;
  logic signed [LON_W-1:0] cur_lon = '0;
  fix_result_t             pending_results [$];
  int                      results_seen = 0;
  int                      mismatches = 0;
  int                      stall_cycles = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  logic                    long_hold_done = 1'b0;

  waypoint_bearing_heading_error dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .boat_lat_i       (boat_lat),
    .boat_lon_i       (boat_lon),
    .boat_heading_i   (boat_heading),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .target_bearing_o (target_bearing),
    .heading_error_o  (heading_error)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic logic [ANG_W-1:0] bearing_to(input longint north, input longint east);
    longint x;
    longint y;
    longint x_old;
    longint acc;
    longint full;
    longint rounded;
    int     i;
    if (north == 0 && east == 0) begin
      return '0;
    end
    x = north <<< VEC_SHIFT;
    y = east <<< VEC_SHIFT;
    acc = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = longint'(DEG180) <<< FRAC_BITS;
    end
    for (i = 0; i < NSTEP; i++) begin
      x_old = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (x_old >>> i);
        acc = acc + ATAN_STEP[i];
      end else begin
        x = x - (y >>> i);
        y = y + (x_old >>> i);
        acc = acc - ATAN_STEP[i];
      end
    end
    full = longint'(DEG360) <<< FRAC_BITS;
    while (acc < 0) acc = acc + full;
    while (acc >= full) acc = acc - full;
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rounded >= DEG360) begin
      rounded = rounded - DEG360;
    end
    return rounded[ANG_W-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] heading_error_of(input logic [ANG_W-1:0] bearing,
                                                               input logic [HEAD_W-1:0] head);
    int wrapped;
    wrapped = (int'(bearing) + DEG720 - int'(head)) % DEG360;
    if (wrapped >= DEG180) begin
      wrapped = wrapped - DEG360;
    end
    return wrapped[ANG_W-1:0];
  endfunction

  // register shadow, expected results, result check and stall watchdog
  always @(posedge clk_i) begin
    fix_result_t want;
    fix_result_t got;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TARGET_LAT) begin
        cur_lat = cfg_data[LAT_W-1:0];
      end else if (cfg_index == REG_TARGET_LON) begin
        cur_lon = cfg_data[LON_W-1:0];
      end
    end
    if (in_valid && in_ready) begin
      if (row_typed) begin
        want.bearing = row_bearing;
        want.herr = row_herr;
      end else begin
        want.bearing = bearing_to(longint'(cur_lat) - longint'(boat_lat),
                                  longint'(cur_lon) - longint'(boat_lon));
        want.herr = heading_error_of(want.bearing, boat_heading);
      end
      pending_results = {pending_results, want};
    end
    if (out_valid && out_ready) begin
      results_seen++;
      got.bearing = target_bearing;
      got.herr = heading_error;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: bearing %0d, error %0d", got.bearing, got.herr);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.bearing !== want.bearing) begin
          $error("target_bearing: expected %0d, got %0d", want.bearing, got.bearing);
          mismatches++;
        end
        if (got.herr !== want.herr) begin
          $error("heading_error: expected %0d, got %0d", want.herr, got.herr);
          mismatches++;
        end
      end
    end
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // output back-pressure, with one long hold once the run is under way
  initial begin
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 400) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_fix(input fix_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    boat_lat     <= row.lat;
    boat_lon     <= row.lon;
    boat_heading <= row.head;
    row_typed    <= row.typed;
    row_bearing  <= row.bearing;
    row_herr     <= row.herr;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input wbhe_reg_e idx, input logic [CFG_DW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_target(input logic [CFG_DW-1:0] lat_word, input logic [CFG_DW-1:0] lon_word);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    write_reg(REG_TARGET_LAT, lat_word);
    write_reg(REG_TARGET_LON, lon_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic fix_row_t random_fix();
    fix_row_t row;
    int       kind;
    int       dn;
    int       de;
    row = '0;
    kind = $urandom_range(99);
    if (kind < 55) begin
      row.lat = LAT_W'(int'($urandom_range(1800000000)) - 900000000);
      row.lon = LON_W'(longint'($urandom_range(32'd3600000000, 0)) - 64'sd1800000000);
    end else if (kind < 85) begin
      dn = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(40000)) - 20000;
      de = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(40000)) - 20000;
      row.lat = cur_lat - LAT_W'(dn);
      row.lon = cur_lon - LON_W'(de);
    end else begin
      row.lat = LAT_W'($urandom);
      row.lon = $urandom;
    end
    row.head = ($urandom_range(99) < 85) ? HEAD_W'($urandom_range(35999)) : HEAD_W'($urandom);
    return row;
  endfunction

  initial begin
    logic [CFG_DW-1:0] lat_word;
    logic [CFG_DW-1:0] lon_word;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      send_fix(FIX_TABLE[r]);
    end

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          lat_word = CFG_DW'(int'($urandom_range(1800000000)) - 900000000);
          lon_word = CFG_DW'(longint'($urandom_range(32'd3600000000, 0)) - 64'sd1800000000);
        end
        1: begin
          lat_word = CFG_DW'(900000000);
          lon_word = CFG_DW'(-1800000000);
        end
        2: begin
          lat_word = CFG_DW'(-900000000);
          lon_word = CFG_DW'(1800000000);
        end
        3: begin
          lat_word = 32'h3fffffff;
          lon_word = 32'h80000000;
        end
        4: begin
          lat_word = 32'hc0000000;
          lon_word = 32'h7fffffff;
        end
        default: begin
          lat_word = $urandom;
          lon_word = $urandom;
        end
      endcase
      set_target(lat_word, lon_word);
      if (seg < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 66;
      end else if (seg < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (SEG_ITEMS) send_fix(random_fix());
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
src/wbhe_pkg.sv
src/wbhe_prep.sv
src/wbhe_cordic.sv
src/wbhe_post.sv
src/waypoint_bearing_heading_error.sv
tb/tb_waypoint_bearing_heading_error.sv
